>>> hw/rtl/sli_pkg.sv
// Shared types and constants for the sorted list insert/remove unit.
// Depends on nothing; every other file of the block imports it.
package sli_pkg;

   // Default number of list entries.
   localparam int unsigned SLI_DEPTH = 16;

   // Width of the data values and of the reported count.
   localparam int unsigned SLI_VALUE_W = 32;
   localparam int unsigned SLI_COUNT_W = 5;

   // Operation codes of an input transfer.
   typedef enum logic {
      KIND_INSERT = 1'b0,
      KIND_REMOVE = 1'b1
   } kind_type;

   // Result status codes.
   typedef enum logic [1:0] {
      STATUS_DONE    = 2'd0,
      STATUS_FULL    = 2'd1,
      STATUS_EMPTY   = 2'd2,
      STATUS_MISSING = 2'd3
   } status_type;

   // Input transfer payload.
   typedef struct packed {
      kind_type                        kind;
      logic signed [SLI_VALUE_W-1:0]   value;
   } req_type;

   // Result transfer payload.
   typedef struct packed {
      status_type                status;
      logic [SLI_COUNT_W-1:0]    count;
   } rsp_type;

   // Sequencer states.
   typedef enum logic [2:0] {
      S_IDLE,
      S_INS_STEP,
      S_INS_HEAD,
      S_REM_STEP,
      S_RESP
   } state_type;

endpackage

>>> hw/rtl/sli_mem.sv
// Entry storage of the sorted list: one write port, one registered read port.
// Depends on sli_pkg for the value width.
module sli_mem #(
   parameter int unsigned DEPTH = sli_pkg::SLI_DEPTH
) (
   input  logic                                   clock,
   input  logic                                   wr_en,
   input  logic [$clog2(DEPTH)-1:0]               wr_addr,
   input  logic signed [sli_pkg::SLI_VALUE_W-1:0] wr_data,
   input  logic [$clog2(DEPTH)-1:0]               rd_addr,
   output logic signed [sli_pkg::SLI_VALUE_W-1:0] rd_data
);
   import sli_pkg::*;

   logic signed [SLI_VALUE_W-1:0] mem_ff [DEPTH];
   logic signed [SLI_VALUE_W-1:0] rd_data_ff;

   // Write port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // Registered read port; returns the old contents on a same-cycle write.
   always_ff @(posedge clock) begin
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

>>> hw/rtl/sorted_list_insert_remove_unit.sv
// Top level of the sorted list insert/remove unit: sequencer and count.
// Depends on sli_pkg for types and on sli_mem for the entry storage.
//
//  Channel   Direction  Handshake               Payload
//  req_      in         req_valid / req_stall   req_payload (kind, value)
//  rsp_      out        rsp_valid / rsp_stall   rsp_payload (status, count)
//
// One item at a time; the walk visits one entry per cycle, an insert with a signed
// compare and a remove with an equality test. The full, empty and first-insert cases
// go straight to the result state, which presents the result until it is taken.
// Reset is synchronous and empties the list; entries are not cleared. req_stall is
// high from acceptance until the result transfer ends.
module sorted_list_insert_remove_unit #(
   parameter int unsigned DEPTH = sli_pkg::SLI_DEPTH
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  sli_pkg::req_type req_payload,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output sli_pkg::rsp_type rsp_payload
);
   import sli_pkg::*;

   localparam int unsigned IdxW = $clog2(DEPTH);
   localparam int unsigned CntW = $clog2(DEPTH + 1);

   state_type                     state_ff, state_in;
   logic [IdxW-1:0]               idx_ff, idx_in;
   logic [CntW-1:0]               cnt_ff, cnt_in;
   logic                          hit_ff, hit_in;
   logic signed [SLI_VALUE_W-1:0] val_ff, val_in;
   rsp_type                       rsp_ff, rsp_in;

   logic                          wr_en;
   logic [IdxW-1:0]               wr_addr;
   logic signed [SLI_VALUE_W-1:0] wr_data;
   logic signed [SLI_VALUE_W-1:0] rd_data;

   logic [CntW-1:0]               cnt_m1;
   logic [IdxW-1:0]               last_idx;
   logic                          hit_now;
   logic [CntW+SLI_COUNT_W-1:0]   cnt_wide;

   sli_mem #(
      .DEPTH(DEPTH)
   ) u_mem (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (idx_in),
      .rd_data (rd_data)
   );

   assign cnt_m1   = cnt_ff - CntW'(1);
   assign last_idx = cnt_m1[IdxW-1:0];
   assign hit_now  = hit_ff | (rd_data == val_ff);
   assign cnt_wide = {{SLI_COUNT_W{1'b0}}, cnt_in};

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         cnt_ff   <= '0;
         hit_ff   <= 1'b0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
         hit_ff   <= hit_in;
      end
   end

   // Working and result registers.
   always_ff @(posedge clock) begin
      idx_ff <= idx_in;
      val_ff <= val_in;
      rsp_ff <= rsp_in;
   end

   // Sequencer: insert walks down from the top shifting greater entries up,
   // remove walks up from the bottom shifting entries after the match down.
   always_comb begin
      state_in = state_ff;
      idx_in   = idx_ff;
      cnt_in   = cnt_ff;
      hit_in   = hit_ff;
      val_in   = val_ff;
      rsp_in   = rsp_ff;
      wr_en    = 1'b0;
      wr_addr  = idx_ff;
      wr_data  = val_ff;

      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               val_in = req_payload.value;
               hit_in = 1'b0;
               if (req_payload.kind == KIND_INSERT) begin
                  if (cnt_ff == CntW'(DEPTH)) begin
                     rsp_in.status = STATUS_FULL;
                     state_in      = S_RESP;
                  end else if (cnt_ff == '0) begin
                     wr_en         = 1'b1;
                     wr_addr       = '0;
                     wr_data       = req_payload.value;
                     cnt_in        = CntW'(1);
                     rsp_in.status = STATUS_DONE;
                     state_in      = S_RESP;
                  end else begin
                     idx_in   = last_idx;
                     state_in = S_INS_STEP;
                  end
               end else begin
                  if (cnt_ff == '0) begin
                     rsp_in.status = STATUS_EMPTY;
                     state_in      = S_RESP;
                  end else begin
                     idx_in   = '0;
                     state_in = S_REM_STEP;
                  end
               end
            end
         end

         S_INS_STEP: begin
            wr_en   = 1'b1;
            wr_addr = idx_ff + IdxW'(1);
            if (rd_data > val_ff) begin
               // Entry moves up one place; keep walking down.
               wr_data = rd_data;
               if (idx_ff == '0) begin
                  state_in = S_INS_HEAD;
               end else begin
                  idx_in = idx_ff - IdxW'(1);
               end
            end else begin
               wr_data       = val_ff;
               cnt_in        = cnt_ff + CntW'(1);
               rsp_in.status = STATUS_DONE;
               state_in      = S_RESP;
            end
         end

         S_INS_HEAD: begin
            wr_en         = 1'b1;
            wr_addr       = '0;
            wr_data       = val_ff;
            cnt_in        = cnt_ff + CntW'(1);
            rsp_in.status = STATUS_DONE;
            state_in      = S_RESP;
         end

         S_REM_STEP: begin
            hit_in = hit_now;
            // After the match, each entry moves down one place.
            if (hit_ff) begin
               wr_en   = 1'b1;
               wr_addr = idx_ff - IdxW'(1);
               wr_data = rd_data;
            end
            if (idx_ff == last_idx) begin
               if (hit_now) begin
                  cnt_in        = cnt_m1;
                  rsp_in.status = STATUS_DONE;
               end else begin
                  rsp_in.status = STATUS_MISSING;
               end
               state_in = S_RESP;
            end else begin
               idx_in = idx_ff + IdxW'(1);
            end
         end

         S_RESP: begin
            if (!rsp_stall) begin
               state_in = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase

      // Capture the count as the result is loaded.
      if (state_in == S_RESP && state_ff != S_RESP) begin
         rsp_in.count = cnt_wide[SLI_COUNT_W-1:0];
      end
   end

   assign req_stall   = (state_ff != S_IDLE);
   assign rsp_valid   = (state_ff == S_RESP);
   assign rsp_payload = rsp_ff;

endmodule
